// File: src/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEF_W = 32;
    localparam int ROOT_W = 48;
    localparam int DISC_W = 67;

    typedef enum logic [1:0]
    {
        CNT_NONE     = 2'd0,
        CNT_ONE      = 2'd1,
        CNT_TWO      = 2'd2,
        CNT_INFINITE = 2'd3
    } root_count_t;

    typedef enum logic
    {
        CFG_COEF_TOL = 1'b0,
        CFG_DISC_TOL = 1'b1
    } cfg_index_t;

    // Division job: numerator and denominator as magnitudes with a sign.
    typedef struct packed
    {
        logic        neg;
        logic        num_neg;
        logic [33:0] num_mag;
        logic [32:0] den_mag;
    } div_job_t;

endpackage

// File: src/qrs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_divider
#(
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  qrs_pkg::div_job_t              job,
    input  logic [TAG_W-1:0]               tag_in,
    output logic signed [qrs_pkg::ROOT_W-1:0] quo,
    output logic                           ovf,
    output logic [TAG_W-1:0]               tag_out
);
    import qrs_pkg::*;

    // The dividend is num_mag << FRAC_BITS.
    localparam int N_W = 34 + FRAC_BITS;
    localparam int R_W = 34;

    logic [N_W-1:0]   num_reg   [N_W+1];
    logic [N_W-1:0]   q_reg     [N_W+1];
    logic [R_W-1:0]   rem_reg   [N_W+1];
    logic [32:0]      den_reg   [N_W+1];
    logic             neg_reg   [N_W+1];
    logic             nneg_reg  [N_W+1];
    logic [TAG_W-1:0] tag_reg   [N_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= {job.num_mag, {FRAC_BITS{1'b0}}};
            q_reg[0]    <= '0;
            rem_reg[0]  <= '0;
            den_reg[0]  <= job.den_mag;
            neg_reg[0]  <= job.neg;
            nneg_reg[0] <= job.num_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg[0] <= '0;
        else if (en)
            tag_reg[0] <= tag_in;
    end

    for (genvar i = 0; i < N_W; i++)
    begin : g_step
        logic [R_W:0] trial;
        logic [R_W:0] shifted;
        assign shifted = {rem_reg[i], num_reg[i][N_W-1-i]};
        assign trial   = shifted - {2'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i+1]  <= num_reg[i];
                den_reg[i+1]  <= den_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                nneg_reg[i+1] <= nneg_reg[i];
                q_reg[i+1]    <= {q_reg[i][N_W-2:0], ~trial[R_W]};
                rem_reg[i+1]  <= trial[R_W] ? shifted[R_W-1:0] : trial[R_W-1:0];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[i+1] <= '0;
            else if (en)
                tag_reg[i+1] <= tag_reg[i];
        end
    end

    // Limits are kept at 64 bits, which holds the quotient for fraction widths up to 30.
    localparam logic [63:0] MAX_POS = (64'd1 << (ROOT_W - 1)) - 64'd1;
    localparam logic [63:0] MAX_NEG = 64'd1 << (ROOT_W - 1);

    logic [63:0] q_fin;
    logic [63:0] lim;
    logic        zero_den;
    assign q_fin    = 64'(q_reg[N_W]);
    assign lim      = neg_reg[N_W] ? MAX_NEG : MAX_POS;
    assign zero_den = (den_reg[N_W] == '0);

    always_comb
    begin
        priority if (zero_den)
        begin
            ovf = 1'b1;
            if (num_reg[N_W] == '0)
                quo = '0;
            else if (nneg_reg[N_W])
                quo = ROOT_W'(-MAX_NEG);
            else
                quo = ROOT_W'(MAX_POS);
        end
        else if (q_fin > lim)
        begin
            ovf = 1'b1;
            quo = neg_reg[N_W] ? ROOT_W'(-lim) : ROOT_W'(lim);
        end
        else
        begin
            ovf = 1'b0;
            quo = neg_reg[N_W] ? ROOT_W'(-q_fin) : ROOT_W'(q_fin);
        end
    end

    assign tag_out = tag_reg[N_W];

endmodule

// File: src/qrs_sqrt.sv
// Pipelined floor square root of a 66-bit value, one result bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt
#(
    parameter int PASS_W = 8
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [65:0]       rad,
    input  logic [PASS_W-1:0] pass_in,
    output logic [33:0]       root,
    output logic [PASS_W-1:0] pass_out
);
    import qrs_pkg::*;

    localparam int STEPS = 33;

    logic [65:0]       rad_reg  [STEPS+1];
    logic [33:0]       r_reg    [STEPS+1];
    logic [67:0]       rem_reg  [STEPS+1];
    logic [PASS_W-1:0] pass_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            r_reg[0]    <= '0;
            rem_reg[0]  <= '0;
            pass_reg[0] <= pass_in;
        end
    end

    // Digit-by-digit: bring down two radicand bits, try 4r+1.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [67:0] cur;
        logic [67:0] trial;
        assign cur   = {rem_reg[i][65:0], rad_reg[i][65-2*i -: 2]};
        assign trial = cur - {32'd0, r_reg[i], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i+1]  <= rad_reg[i];
                pass_reg[i+1] <= pass_reg[i];
                r_reg[i+1]    <= {r_reg[i][32:0], ~trial[67]};
                rem_reg[i+1]  <= trial[67] ? cur : trial;
            end
        end
    end

    assign root     = r_reg[STEPS];
    assign pass_out = pass_reg[STEPS];

endmodule

// File: src/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, square root, dividers.
// Depends on qrs_pkg, qrs_sqrt and qrs_divider.
`timescale 1ns / 1ps

// Solves a*x^2+b*x+c=0 for signed Q15.16 coefficients and returns a root count
// with two Q31.16 roots and a saturation flag. The block is one long pipeline
// that takes one equation beat per cycle. Its stages are two front-end
// stages (classification and the exact 66-bit discriminant, with the products
// split into two 33x33 multipliers), 34 square-root stages (an input register
// and 33 digit steps), one numerator stage, 35+FRAC_BITS divider stages (an
// input register and one step per quotient bit) and an output register. The whole
// pipeline advances together whenever the output register is free or being
// emptied, so a stall on the result side holds every beat in place. Tolerances
// are sampled when an equation enters; write them only while the pipeline is
// empty.
module quadratic_root_solver
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    // Slave side: tdata = {coef_c, coef_b, coef_a}, coef_a in the lowest bits.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,
    // Master side: tdata = root_count[1:0], root_first[49:2],
    // root_second[97:50], overflow[98], zero fill to bit 103.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);
    import qrs_pkg::*;

    logic [15:0] coef_tol_reg;
    logic [31:0] disc_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_tol_reg <= '0;
            disc_tol_reg <= 32'd4295;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COEF_TOL: coef_tol_reg <= cfg_data[15:0];
                CFG_DISC_TOL: disc_tol_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output register can take a beat.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- Stage 1: magnitudes, zero tests, products ----------------
    logic signed [31:0] a_in, b_in, c_in;
    assign a_in = s_tdata[31:0];
    assign b_in = s_tdata[63:32];
    assign c_in = s_tdata[95:64];

    logic [32:0] ma, mb, mc;
    assign ma = a_in[31] ? 33'(-34'(a_in)) : 33'(a_in);
    assign mb = b_in[31] ? 33'(-34'(b_in)) : 33'(b_in);
    assign mc = c_in[31] ? 33'(-34'(c_in)) : 33'(c_in);

    logic v1_reg;
    logic signed [31:0] a1_reg, b1_reg, c1_reg;
    logic za1_reg, zb1_reg, zc1_reg;
    logic [65:0] b2_reg, ac_reg;
    logic [31:0] dtol1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a_in;
            b1_reg    <= b_in;
            c1_reg    <= c_in;
            za1_reg   <= ma < {17'd0, coef_tol_reg};
            zb1_reg   <= mb < {17'd0, coef_tol_reg};
            zc1_reg   <= mc < {17'd0, coef_tol_reg};
            b2_reg    <= mb * mb;
            ac_reg    <= ma * mc;
            dtol1_reg <= disc_tol_reg;
        end
    end

    // ---------------- Stage 2: discriminant and case decision ----------------
    typedef enum logic [2:0]
    {
        K_ZERO, K_INF, K_LIN, K_CZERO, K_DZERO, K_DNEG, K_TWO
    } kind_t;

    logic [67:0] four_ac, b2x, dsum, ddiff;
    logic        opp_sign, dneg, dzero;
    logic [65:0] dmag;
    kind_t       kind;
    assign four_ac  = {ac_reg, 2'b00};
    assign b2x      = {2'b00, b2_reg};
    assign opp_sign = (ac_reg == '0) || (a1_reg[31] != c1_reg[31]);
    assign dsum     = b2x + four_ac;
    assign ddiff    = b2x - four_ac;
    assign dneg     = !opp_sign && ddiff[67];
    always_comb
    begin
        priority if (opp_sign)
            dmag = dsum[65:0];
        else if (dneg)
            dmag = 66'(-ddiff);
        else
            dmag = ddiff[65:0];
    end
    assign dzero = dmag < {34'd0, dtol1_reg};

    always_comb
    begin
        priority if (za1_reg && zb1_reg)
            kind = zc1_reg ? K_INF : K_ZERO;
        else if (za1_reg)
            kind = K_LIN;
        else if (!zb1_reg && zc1_reg)
            kind = K_CZERO;
        else if (dzero)
            kind = K_DZERO;
        else if (dneg)
            kind = K_DNEG;
        else
            kind = K_TWO;
    end

    logic v2_reg;
    logic signed [31:0] a2_reg, b2c_reg, c2_reg;
    kind_t kind2_reg;
    logic [65:0] rad2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= a1_reg;
            b2c_reg   <= b1_reg;
            c2_reg    <= c1_reg;
            kind2_reg <= kind;
            rad2_reg  <= (kind == K_TWO) ? dmag : '0;
        end
    end

    // ---------------- Square root stages ----------------
    localparam int PASS_W = 1 + 3 + 96;
    logic [PASS_W-1:0] sq_pass_in, sq_pass_out;
    logic [33:0]       s_root;
    assign sq_pass_in = {v2_reg, kind2_reg, c2_reg, b2c_reg, a2_reg};

    qrs_sqrt #(.PASS_W(PASS_W)) u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .rad      (rad2_reg),
        .pass_in  (sq_pass_in),
        .root     (s_root),
        .pass_out (sq_pass_out)
    );

    logic               v3;
    logic [2:0]         k3_bits;
    kind_t              k3;
    logic signed [31:0] a3, b3, c3;
    assign {v3, k3_bits, c3, b3, a3} = sq_pass_out;
    assign k3 = kind_t'(k3_bits);

    // ---------------- Numerator/denominator selection ----------------
    logic signed [34:0] nb, s_ext, num1, num2;
    logic signed [33:0] den;
    assign nb    = -35'(b3);
    assign s_ext = 35'(signed'({1'b0, s_root}));
    always_comb
    begin
        num1 = '0;
        num2 = '0;
        den  = 34'(a3) <<< 1;
        unique case (k3)
            K_LIN:
            begin
                num1 = -35'(c3);
                num2 = num1;
                den  = 34'(b3);
            end
            K_CZERO:
            begin
                num2 = nb;
                den  = 34'(a3);
            end
            K_DZERO:
            begin
                num1 = nb;
                num2 = nb;
            end
            K_TWO:
            begin
                num1 = nb + s_ext;
                num2 = nb - s_ext;
            end
            default: ;
        endcase
    end

    div_job_t job1_reg, job2_reg;
    logic     v4_reg;
    kind_t    k4_reg;

    function automatic div_job_t mk_job(input logic signed [34:0] n,
                                        input logic signed [33:0] d);
        div_job_t j;
        j.num_neg = n[34];
        j.num_mag = n[34] ? 34'(-n) : n[33:0];
        j.den_mag = d[33] ? 33'(-d) : d[32:0];
        j.neg     = n[34] != d[33];
        return j;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job1_reg <= mk_job(num1, den);
            job2_reg <= mk_job(num2, den);
            k4_reg   <= k3;
        end
    end

    // ---------------- Dividers ----------------
    localparam int TAG_W = 4;
    logic [TAG_W-1:0]          tag_out, tag_unused;
    logic signed [ROOT_W-1:0]  q1, q2;
    logic                      o1, o2;

    qrs_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div1
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .job     (job1_reg),
        .tag_in  ({v4_reg, k4_reg}),
        .quo     (q1),
        .ovf     (o1),
        .tag_out (tag_out)
    );

    qrs_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div2
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .job     (job2_reg),
        .tag_in  ({v4_reg, k4_reg}),
        .quo     (q2),
        .ovf     (o2),
        .tag_out (tag_unused)
    );

    kind_t k5;
    assign k5 = kind_t'(tag_out[2:0]);

    // ---------------- Output register ----------------
    root_count_t             cnt;
    logic signed [ROOT_W-1:0] r1, r2;
    logic                     ov;
    always_comb
    begin
        r1  = '0;
        r2  = '0;
        ov  = 1'b0;
        cnt = CNT_NONE;
        unique case (k5)
            K_INF:   cnt = CNT_INFINITE;
            K_LIN:   begin cnt = CNT_ONE; r1 = q1; r2 = q1; ov = o1; end
            K_CZERO: begin cnt = CNT_TWO; r2 = q2; ov = o2; end
            K_DZERO: begin cnt = CNT_ONE; r1 = q1; r2 = q1; ov = o1; end
            K_TWO:   begin cnt = CNT_TWO; r1 = q1; r2 = q2; ov = o1 | o2; end
            default: ;
        endcase
    end

    logic [103:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= tag_out[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {5'd0, ov, r2, r1, cnt};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stalled result must hold its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_data_reg))
        else $error("result changed while stalled");
    // Upstream is only ready while the output stage can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");
    // No-root results carry zero roots.
    a_noroot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == CNT_NONE) |-> (m_tdata[97:2] == '0))
        else $error("nonzero root with no-root count");

endmodule
